[src/tdfl_pkg.sv]
// tdfl_pkg: shared types, constants and codes of the tail-drop link scheduler
// depends on nothing; imported by tdfl_div and the core top level
`default_nettype none

package tdfl_pkg;

	// field widths fixed by the interface
	localparam int unsigned TIME_W     = 40;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned CLASS_W    = 3;
	localparam int unsigned OCC_W      = 32;
	localparam int unsigned CAP_W      = 32;
	localparam int unsigned BW_W       = 39;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 39;

	// default sizing of the descriptor ring and the time base
	localparam int unsigned MAX_QUEUED_DEF = 64;
	localparam int unsigned TIME_BITS_DEF  = 40;

	// register reset values
	localparam logic [CAP_W-1:0] CAP_RESET = 32'd65536;
	localparam logic [BW_W-1:0]  BW_RESET  = 39'd10000000000;

	// bits to microsecond scale: 8 bits per byte times 1e6
	localparam int unsigned      SCALE_W  = 23;
	localparam logic [SCALE_W-1:0] TX_SCALE = 23'd8000000;
	localparam int unsigned      PROD_W   = SIZE_W + SCALE_W;

	// divider operand widths
	localparam int unsigned DIV_NUM_W = 40;
	localparam int unsigned DIV_DEN_W = BW_W;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAP = 1'b0,
		REG_BW  = 1'b1
	} reg_idx_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_SENT      = 2'd0,
		ST_DROP_BUF  = 2'd1,
		ST_DROP_DESC = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_DECIDE,
		S_MUL,
		S_DIV,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  arr_us;
		logic [SIZE_W-1:0]  len_bytes;
		logic [CLASS_W-1:0] cls_tag;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [TIME_W-1:0]  queue_delay_us;
		logic [TIME_W-1:0]  departure_time_us;
		logic [CLASS_W-1:0] class_out;
		logic [OCC_W-1:0]   occupancy_bytes;
	} result_t;

	// per-item control decoded from the sequencer state
	typedef struct packed {
		logic retire;
		logic drop;
		logic div_load;
		logic commit;
	} seq_ctl_t;

endpackage

`default_nettype wire

[src/tdfl_ram.sv]
// tdfl_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module tdfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/tdfl_div.sv]
// tdfl_div: iterative restoring divider, two quotient bits per cycle,
// result rounded up; depends on tdfl_pkg for default widths
`default_nettype none

module tdfl_div import tdfl_pkg::*; #(
	parameter int unsigned NUM_W = DIV_NUM_W,
	parameter int unsigned DEN_W = DIV_DEN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);

	localparam int unsigned STEPS = 2;
	localparam int unsigned ITER  = NUM_W / STEPS;
	localparam int unsigned IW    = (ITER > 1) ? $clog2(ITER) : 1;
	localparam logic [IW-1:0] ITER_LAST = IW'(ITER - 1);

	logic             run_q, fix_q, done_q;
	logic [IW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q, num_nx, quot_q;
	logic [DEN_W:0]   rem_q, rem_nx;
	logic [DEN_W-1:0] den_q;

	// two shift-subtract steps; quotient bits enter at the low end of num
	always_comb begin
		rem_nx = rem_q;
		num_nx = num_q;
		for (int k = 0; k < STEPS; k++) begin
			rem_nx = {rem_nx[DEN_W-1:0], num_nx[NUM_W-1]};
			num_nx = {num_nx[NUM_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, den_q}) begin
				rem_nx    = rem_nx - {1'b0, den_q};
				num_nx[0] = 1'b1;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_LAST) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands, partial remainder and rounded quotient
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
		if (fix_q) begin
			quot_q <= num_q + NUM_W'(rem_q != '0);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

[src/tail_drop_fifo_link_scheduler_core.sv]
// tail_drop_fifo_link_scheduler_core: byte-counted tail-drop link queue model
// depends on tdfl_pkg, tdfl_ram and tdfl_div
//
// Usage: pulse start with a packet on item while busy is low; the beat is
// taken at that edge and busy stays high until the result. Each packet gives
// one result beat on result, valid for the single cycle in which done is high;
// the receiver cannot stall and must take it then. Busy is already low in
// that cycle, so the next packet may be started alongside the result.
// First the head of the descriptor ring is checked in S_RD and S_CMP, and each
// queued packet that has departed by the arrival time is retired. A dropped
// packet then gets its result in S_DECIDE; a queued one passes S_MUL and waits
// in S_DIV for the shared divider that works out the transmission time at two
// quotient bits per cycle, then commits in S_FIN. One packet is worked on at a time.
// The config port (cfg_we, cfg_index, cfg_data) writes the buffer capacity or
// the link rate and is meant to be used while busy is low.
// Reset empties the queue, zeroes occupancy and last departure, and restores
// the register defaults; the descriptor RAMs need no clearing pass.
`default_nettype none

module tail_drop_fifo_link_scheduler_core import tdfl_pkg::*; #(
	parameter int unsigned MAX_QUEUED_PACKETS = MAX_QUEUED_DEF,
	parameter int unsigned TIME_BITS          = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire item_t                 item,
	output logic                       done,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = (MAX_QUEUED_PACKETS > 1) ? $clog2(MAX_QUEUED_PACKETS) : 1;
	localparam int unsigned CW = $clog2(MAX_QUEUED_PACKETS + 1);
	localparam int unsigned W  = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
	localparam logic [W-1:0]    TIME_MAX  = W'({TIME_BITS{1'b1}});
	localparam logic [CW:0]     DEPTH_X   = (CW+1)'(MAX_QUEUED_PACKETS);
	localparam logic [CW-1:0]   DEPTH_C   = CW'(MAX_QUEUED_PACKETS);
	localparam logic [AW-1:0]   LAST_SLOT = AW'(MAX_QUEUED_PACKETS - 1);

	seq_state_t state_q, state_nx;
	seq_ctl_t   ctl;

	logic [CAP_W-1:0]     cap_q;
	logic [BW_W-1:0]      bw_q;
	logic [TIME_W-1:0]    arrival_q;
	logic [SIZE_W-1:0]    size_q;
	logic [CLASS_W-1:0]   class_q;
	logic [AW-1:0]        head_q, head_inc, slot;
	logic [CW-1:0]        count_q;
	logic [OCC_W-1:0]     total_q;
	logic [TIME_BITS-1:0] last_dep_q;
	logic [W-1:0]         start_q, start_pick, start_sat, depart, delay;
	logic [W:0]           dep_sum;
	logic [CW:0]          slot_sum, slot_wrap;
	logic [CAP_W:0]       need;
	result_t              result_q;
	logic                 done_q;

	logic [TIME_BITS-1:0] rd_time;
	logic [SIZE_W-1:0]    rd_size;
	logic                 head_due, over_cap, ring_full;

	logic [PROD_W-1:0]    tx_bits;
	logic [BW_W-1:0]      div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;

	// descriptor ring: departure time and size per queued packet
	tdfl_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_QUEUED_PACKETS)
	) u_time_ram (
		.clk   (clk),
		.we    (ctl.commit),
		.waddr (slot),
		.wdata (depart[TIME_BITS-1:0]),
		.raddr (head_q),
		.rdata (rd_time)
	);

	tdfl_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (MAX_QUEUED_PACKETS)
	) u_size_ram (
		.clk   (clk),
		.we    (ctl.commit),
		.waddr (slot),
		.wdata (size_q),
		.raddr (head_q),
		.rdata (rd_size)
	);

	// transmission time: ceil(size * 8e6 / rate), zero rate taken as one
	assign tx_bits = {{SCALE_W{1'b0}}, size_q} * {{SIZE_W{1'b0}}, TX_SCALE};
	assign div_den = (bw_q == '0) ? BW_W'(1) : bw_q;

	tdfl_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (BW_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl.div_load),
		.num    (DIV_NUM_W'(tx_bits)),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// head retirement and admission checks
	assign head_due  = W'(rd_time) <= W'(arrival_q);
	assign need      = {1'b0, total_q} + (CAP_W+1)'(size_q);
	assign over_cap  = need > {1'b0, cap_q};
	assign ring_full = count_q >= DEPTH_C;
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;

	// tail slot of the ring
	always_comb begin
		slot_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
		slot_wrap = (slot_sum >= DEPTH_X) ? slot_sum - DEPTH_X : slot_sum;
	end
	assign slot = slot_wrap[AW-1:0];

	// start time, saturated to the time range
	assign start_pick = (W'(arrival_q) > W'(last_dep_q)) ? W'(arrival_q) : W'(last_dep_q);
	assign start_sat  = (start_pick > TIME_MAX) ? TIME_MAX : start_pick;

	// departure and queueing delay
	assign dep_sum = {1'b0, start_q} + (W+1)'(div_quot);
	assign depart  = (dep_sum > {1'b0, TIME_MAX}) ? TIME_MAX : dep_sum[W-1:0];
	assign delay   = (start_q > W'(arrival_q)) ? start_q - W'(arrival_q) : '0;

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				state_nx = (count_q == '0) ? S_DECIDE : S_CMP;
			end
			S_CMP: begin
				state_nx = head_due ? S_RD : S_DECIDE;
			end
			S_DECIDE: begin
				state_nx = (over_cap || ring_full) ? S_IDLE : S_MUL;
			end
			S_MUL: begin
				state_nx = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			S_CMP:    ctl.retire   = head_due;
			S_DECIDE: ctl.drop     = over_cap || ring_full;
			S_MUL:    ctl.div_load = 1'b1;
			S_FIN:    ctl.commit   = 1'b1;
			default:  ctl = '0;
		endcase
	end

	// control state, queue bookkeeping and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cap_q      <= CAP_RESET;
			bw_q       <= BW_RESET;
			head_q     <= '0;
			count_q    <= '0;
			total_q    <= '0;
			last_dep_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= ctl.drop || ctl.commit;
			if (cfg_we) begin
				case (cfg_index)
					REG_CAP: cap_q <= cfg_data[CAP_W-1:0];
					REG_BW:  bw_q  <= cfg_data[BW_W-1:0];
					default: ;
				endcase
			end
			if (ctl.retire) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
				total_q <= total_q - OCC_W'(rd_size);
			end
			if (ctl.commit) begin
				count_q    <= count_q + 1'b1;
				total_q    <= total_q + OCC_W'(size_q);
				last_dep_q <= depart[TIME_BITS-1:0];
			end
		end
	end

	// packet beat capture, start time and result register
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			arrival_q <= item.arr_us;
			size_q    <= item.len_bytes;
			class_q   <= item.cls_tag;
		end
		if (ctl.div_load) begin
			start_q <= start_sat;
		end
		if (ctl.drop) begin
			result_q.status            <= over_cap ? ST_DROP_BUF : ST_DROP_DESC;
			result_q.queue_delay_us    <= '0;
			result_q.departure_time_us <= '0;
			result_q.class_out         <= class_q;
			result_q.occupancy_bytes   <= total_q;
		end else if (ctl.commit) begin
			result_q.status            <= ST_SENT;
			result_q.queue_delay_us    <= delay[TIME_W-1:0];
			result_q.departure_time_us <= depart[TIME_W-1:0];
			result_q.class_out         <= class_q;
			result_q.occupancy_bytes   <= total_q + OCC_W'(size_q);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("descriptor count above ring depth");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (total_q == '0))
		else $error("empty ring with nonzero byte total");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_RD))
		else $error("accepted packet did not start head check");
`endif

endmodule

`default_nettype wire

[tb/sv/tdfl_link_checker.sv]
// tdfl_link_checker: watches the packet, result and register channels of the link
// scheduler, predicts each result beat and compares it field by field
// depends on tdfl_pkg for the beat structs, status codes and register indexes
`timescale 1ns / 100ps

module tdfl_link_checker import tdfl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire item_t                 item,
	input  wire logic                  done,
	input  wire result_t               result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned                mismatches,
	output int unsigned                pending,
	output int unsigned                n_sent,
	output int unsigned                n_buf_drop,
	output int unsigned                n_desc_drop
);

	localparam int unsigned RING_DEPTH = MAX_QUEUED_DEF;
	localparam logic [63:0] TIME_LIMIT = (64'd1 << TIME_BITS_DEF) - 64'd1;
	// bits per byte times microseconds per second
	localparam logic [63:0] BYTE_BIT_US = 64'd8000000;
	localparam int unsigned PRINT_CAP  = 40;

	// shadow of the link registers
	logic [CAP_W-1:0] cap_bytes;
	logic [BW_W-1:0]  link_bps;

	// shadow of the descriptor ring and link timeline
	logic [TIME_W-1:0] ring_time [RING_DEPTH];
	logic [SIZE_W-1:0] ring_size [RING_DEPTH];
	int unsigned       ring_head;
	int unsigned       ring_count;
	logic [OCC_W-1:0]  occ_bytes;
	logic [TIME_W-1:0] last_dep;

	// result beats predicted but not yet seen
	result_t sched_q[$];
	result_t next_want;

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// retire departed packets, then queue or drop the new one
	task automatic schedule_packet(input item_t p, output result_t r);
		logic [63:0] need;
		logic [63:0] bits;
		logic [63:0] bw;
		logic [63:0] tx;
		logic [63:0] tx_start;
		logic [63:0] depart;
		logic [63:0] lag;
		int unsigned slot;
		r = '0;
		r.status = ST_SENT;
		r.class_out = p.cls_tag;
		while (ring_count != 0 && ring_time[ring_head] <= p.arr_us) begin
			occ_bytes = occ_bytes - OCC_W'(ring_size[ring_head]);
			ring_head = (ring_head + 1) % RING_DEPTH;
			ring_count--;
		end
		need = 64'(occ_bytes);
		need = need + 64'(p.len_bytes);
		if (need > 64'(cap_bytes)) begin
			r.status = ST_DROP_BUF;
		end else if (ring_count >= RING_DEPTH) begin
			r.status = ST_DROP_DESC;
		end else begin
			tx_start = 64'(p.arr_us);
			if (last_dep > p.arr_us)
				tx_start = 64'(last_dep);
			bw = 64'(link_bps);
			// a zero rate counts as one bit per second
			if (bw == 0)
				bw = 64'd1;
			bits = 64'(p.len_bytes);
			bits = bits * BYTE_BIT_US;
			tx = (bits + bw - 64'd1) / bw;
			// departure saturates at the top of the time base
			depart = (tx > TIME_LIMIT - tx_start) ? TIME_LIMIT : tx_start + tx;
			lag = tx_start - 64'(p.arr_us);
			r.queue_delay_us = lag[TIME_W-1:0];
			r.departure_time_us = depart[TIME_W-1:0];
			slot = (ring_head + ring_count) % RING_DEPTH;
			ring_time[slot] = depart[TIME_W-1:0];
			ring_size[slot] = p.len_bytes;
			ring_count++;
			occ_bytes = occ_bytes + OCC_W'(p.len_bytes);
			last_dep = depart[TIME_W-1:0];
		end
		r.occupancy_bytes = occ_bytes;
	endtask

	// compare a result beat with the oldest prediction
	task automatic check_beat(input result_t got);
		result_t want;
		if (sched_q.size() == 0) begin
			report_mismatch("result beat with no packet outstanding");
		end else begin
			want = sched_q[0];
			sched_q.delete(0);
			check_field("status", 64'(got.status), 64'(want.status));
			check_field("queue_delay_us", 64'(got.queue_delay_us),
				64'(want.queue_delay_us));
			check_field("departure_time_us", 64'(got.departure_time_us),
				64'(want.departure_time_us));
			check_field("class_out", 64'(got.class_out), 64'(want.class_out));
			check_field("occupancy_bytes", 64'(got.occupancy_bytes),
				64'(want.occupancy_bytes));
		end
	endtask

	// sample all channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_bytes = CAP_RESET;
			link_bps = BW_RESET;
			ring_head = 0;
			ring_count = 0;
			occ_bytes = '0;
			last_dep = '0;
			sched_q.delete();
			pending = 0;
			mismatches = 0;
			n_sent = 0;
			n_buf_drop = 0;
			n_desc_drop = 0;
		end else begin
			if (done)
				check_beat(result);
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_CAP: cap_bytes = cfg_data[CAP_W-1:0];
					REG_BW:  link_bps = cfg_data[BW_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				schedule_packet(item, next_want);
				sched_q.push_back(next_want);
				case (next_want.status)
					ST_SENT:      n_sent++;
					ST_DROP_BUF:  n_buf_drop++;
					ST_DROP_DESC: n_desc_drop++;
					default: ;
				endcase
			end
			pending = sched_q.size();
		end
	end

endmodule

[tb/sv/tail_drop_fifo_link_scheduler_core_tb.sv]
// tail_drop_fifo_link_scheduler_core_tb: clock, reset and packet stimulus for the
// link scheduler core, with tdfl_link_checker alongside for prediction
// depends on tdfl_pkg, the core and tdfl_link_checker
`timescale 1ns / 100ps

module tail_drop_fifo_link_scheduler_core_tb import tdfl_pkg::*;;

	localparam logic [TIME_W-1:0] TIME_TOP = '1;
	localparam int unsigned NUM_PHASES      = 7;
	localparam int unsigned LAST_PHASE      = NUM_PHASES - 1;
	localparam int unsigned ITEMS_PER_PHASE = 85;
	localparam int unsigned SETTLE_CYCLES   = 200;
	localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  done;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned n_sent;
	int unsigned n_buf_drop;
	int unsigned n_desc_drop;

	logic [TIME_W-1:0] arrival_now;
	int unsigned       link_settings;

	tail_drop_fifo_link_scheduler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tdfl_link_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pending     (pending),
		.n_sent      (n_sent),
		.n_buf_drop  (n_buf_drop),
		.n_desc_drop (n_desc_drop)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hold start with the packet until the edge that takes the beat
	task automatic send_packet(input logic [TIME_W-1:0] at, input logic [SIZE_W-1:0] sz,
			input logic [CLASS_W-1:0] cls);
		item_t p;
		p.arr_us = at;
		p.len_bytes = sz;
		p.cls_tag = cls;
		start <= 1'b1;
		item <= p;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// wait for every outstanding result beat
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_link(input logic [CFG_DATA_W-1:0] cap, input logic [CFG_DATA_W-1:0] bw);
		cfg_we <= 1'b1;
		cfg_index <= REG_CAP;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= REG_BW;
		cfg_data <= bw;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		link_settings++;
	endtask

	// mostly small forward steps, some big jumps and a few steps back
	task automatic advance_arrival(input int unsigned step_cap);
		logic [63:0] t;
		int unsigned pick;
		t = 64'(arrival_now);
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			if (t > 64'(step_cap))
				t = t - 64'($urandom_range(0, step_cap));
			else
				t = '0;
		end else if (pick < 8) begin
			t = t + 64'($urandom);
		end else begin
			t = t + 64'($urandom_range(0, step_cap));
		end
		arrival_now = (t[63:TIME_W] != 0) ? TIME_TOP : t[TIME_W-1:0];
	endtask

	task automatic run_phase(input int unsigned ph);
		int unsigned step_cap;
		int unsigned size_top;
		int unsigned burst_left;
		logic [CFG_DATA_W-1:0] cap;
		logic [CFG_DATA_W-1:0] bw;
		logic [63:0] wide;
		logic [SIZE_W-1:0] sz;
		case (ph)
			0: begin
				cap = CFG_DATA_W'(CAP_RESET);
				bw = BW_RESET;
				step_cap = 40;
				size_top = 65535;
			end
			// one bit per second: the descriptor store fills up
			1: begin
				cap = '1;
				bw = 39'd1;
				step_cap = 2;
				size_top = 15;
			end
			// capacity dropped under the queued bytes left over
			2: begin
				cap = CFG_DATA_W'($urandom_range(0, 40));
				bw = 39'd400000000000;
				step_cap = 50;
				size_top = 65535;
			end
			3: begin
				cap = CFG_DATA_W'($urandom);
				bw = '1;
				step_cap = 3;
				size_top = 65535;
			end
			4: begin
				cap = CFG_DATA_W'($urandom_range(0, 200000));
				wide = 64'd1000000 + ({$urandom, $urandom} % 64'd399999000000);
				bw = wide[CFG_DATA_W-1:0];
				step_cap = $urandom_range(1, 1000);
				size_top = 65535;
			end
			// zero capacity and zero rate: only empty packets get through
			5: begin
				cap = '0;
				bw = '0;
				step_cap = 5;
				size_top = 3;
			end
			default: begin
				cap = 39'd1048576;
				bw = CFG_DATA_W'($urandom_range(1, 1000000));
				step_cap = 100000;
				size_top = 65535;
			end
		endcase
		// let earlier departures clear before a fresh setting
		if (ph != 2 && ph != LAST_PHASE)
			arrival_now = arrival_now + 40'h08_0000_0000;
		set_link(cap, bw);
		// end of the time base: departures saturate
		if (ph == LAST_PHASE) begin
			send_packet(TIME_TOP - 40'd3, '1, 3'd6);
			send_packet(TIME_TOP, '0, 3'd7);
			send_packet(TIME_TOP, 16'd100, 3'd3);
			arrival_now = TIME_TOP - 40'd4194304;
		end
		burst_left = 0;
		for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 40));
			end
			burst_left--;
			advance_arrival(step_cap);
			case ($urandom_range(0, 9))
				0: sz = '0;
				1: sz = SIZE_W'(size_top);
				default: sz = SIZE_W'($urandom_range(0, size_top));
			endcase
			send_packet(arrival_now, sz, CLASS_W'($urandom_range(0, 7)));
		end
		drain();
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_CAP;
		cfg_data = '0;
		arrival_now = '0;
		link_settings = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: empty packet, full-size packet, buffer edge
		send_packet(40'd0, '0, 3'd0);
		send_packet(40'd0, '1, 3'd7);
		send_packet(40'd0, 16'd2, 3'd1);
		send_packet(40'd0, 16'd1, 3'd2);
		send_packet(40'd10, '0, 3'd3);
		// arrival earlier than the one before
		send_packet(40'd5, 16'd100, 3'd4);
		send_packet(40'd60, 16'd1500, 3'd5);
		drain();

		// zero capacity with zero rate, then all-ones registers
		set_link('0, '0);
		send_packet(40'd1000, '0, 3'd6);
		send_packet(40'd1000, 16'd1, 3'd7);
		drain();
		set_link('1, '1);
		send_packet(40'd2000, '1, 3'd0);
		send_packet(40'd2000, '1, 3'd1);
		drain();

		arrival_now = 40'd3000;
		for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
			run_phase(ph);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d packets over %0d link settings", n_sent + n_buf_drop + n_desc_drop,
			link_settings);
		$display("  %0d queued, %0d dropped on buffer space, %0d dropped on descriptor space",
			n_sent, n_buf_drop, n_desc_drop);
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("run limit reached with %0d result beats outstanding", pending);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
